[hdl/ecl_pkg.sv]
// shared types and constants for the edge contour length block
// no dependencies; every other file imports this package
`timescale 1ns / 1ps

package ecl_pkg;

  localparam int COORD_BITS  = 24;
  localparam int LENGTH_BITS = 40;
  localparam int COUNT_BITS  = 16;

  localparam int ROOT_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int ITER_W = $clog2(ROOT_W + 1);
  localparam int ACC_W  = ((ROOT_W > LENGTH_BITS) ? ROOT_W : LENGTH_BITS) + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t [2:0] point_t;

  typedef enum logic [1:0] {
    OP_SRC   = 2'd0,
    OP_TGT   = 2'd1,
    OP_POINT = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    P_CUR_PREV,
    P_TGT_SRC,
    P_SRC_FIRST,
    P_SRC_PREV,
    P_TGT_PREV,
    P_TGT_FIRST
  } pair_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SEG_SQ,
    S_SEG_RT,
    S_CHECK,
    S_NN_SQ,
    S_NN_RT,
    S_SF,
    S_SL,
    S_TL,
    S_TF,
    S_E1,
    S_E1_SQ,
    S_E1_RT,
    S_E2_SQ,
    S_E2_RT
  } state_e;

  typedef struct packed {
    logic [1:0]       operation;
    coord_t           x;
    coord_t           y;
    coord_t           z;
    logic             last;
  } in_word_t;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] length;
    logic [COUNT_BITS-1:0]  point_count;
  } out_word_t;

  typedef struct packed {
    logic  take;
    logic  store_src;
    logic  store_tgt;
    logic  store_first;
    logic  seg_commit;
    logic  sq_start;
    pair_e pair;
    logic  root_start;
    logic  hold_sq;
    logic  cmp_a;
    logic  cmp_b;
    logic  add_root;
    logic  load_root;
    logic  emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       last;
    logic       cnt_zero;
    logic       sq_done;
    logic       root_done;
    logic       flag_a;
    logic       flag_b;
    logic       out_full;
  } dp_sts_t;

endpackage

[hdl/edge_contour_length.sv]
// top level of the edge contour length block: controller plus datapath
// depends on ecl_pkg, ecl_ctrl and ecl_datapath
// node word: stored as the source or target position, then the next word can be taken
// edge point word: the first point is only stored; each later one adds a squared
//   distance on one shared multiplier and a bit-serial square root
// last word: adds the four end distances and two roots, or one distance and one root
//   for the node-to-node case, plus any wait for the previous result word to leave
// reset (rst_ni low, asynchronous) clears positions, sum, count and control
`timescale 1ns / 1ps

module edge_contour_length (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ecl_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ecl_pkg::out_word_t out_data_o
);
  import ecl_pkg::*;

  // command and status between the sequencer and the datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: one word in flight, walks segment, end-pair and result steps
  ecl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: position store, distance unit, root unit, running sum and
  // result register; the result register lets the next word be taken while
  // a finished length waits on the output side
  ecl_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hdl/ecl_dist.sv]
// squared euclidean distance between two 3-d points, one axis per cycle
// depends on ecl_pkg; one shared multiplier with a product register
`timescale 1ns / 1ps

module ecl_dist (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  ecl_pkg::point_t        a_i,
  input  ecl_pkg::point_t        b_i,
  output logic [ecl_pkg::SQ_W-1:0] sq_o,
  output logic                   done_o
);
  import ecl_pkg::*;

  logic                    busy_q;
  logic [1:0]              axis_q;
  logic [1:0]              idx;
  logic signed [COORD_BITS:0] diff;
  logic [COORD_BITS:0]     mag;
  logic [SQ_W-1:0]         prod_q;
  logic [SQ_W-1:0]         sq_q;

  // axis 3 only drains the product register
  assign idx  = (axis_q == 2'd3) ? 2'd0 : axis_q;
  assign diff = $signed({a_i[idx][COORD_BITS-1], a_i[idx]})
              - $signed({b_i[idx][COORD_BITS-1], b_i[idx]});
  assign mag  = diff[COORD_BITS] ? (COORD_BITS+1)'(0) - diff : diff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      axis_q <= 2'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      axis_q <= 2'd0;
    end else if (busy_q) begin
      axis_q <= axis_q + 2'd1;
      if (axis_q == 2'd3) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sq_q <= '0;
    end else if (busy_q) begin
      if (axis_q != 2'd3) begin
        prod_q <= SQ_W'(mag * mag);
      end
      if (axis_q != 2'd0) begin
        sq_q <= sq_q + prod_q;
      end
    end
  end

  assign sq_o   = sq_q;
  assign done_o = !busy_q;

endmodule

[hdl/ecl_isqrt.sv]
// integer square root, one result bit per cycle (restoring digit method)
// depends on ecl_pkg
`timescale 1ns / 1ps

module ecl_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [ecl_pkg::SQ_W-1:0]  rad_i,
  output logic [ecl_pkg::ROOT_W-1:0] root_o,
  output logic                      done_o
);
  import ecl_pkg::*;

  logic [ITER_W-1:0] iter_q;
  logic [SQ_W-1:0]   rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[SQ_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else if (start_i) begin
      iter_q <= ITER_W'(ROOT_W);
    end else if (iter_q != '0) begin
      iter_q <= iter_q - ITER_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (iter_q != '0) begin
      rad_q  <= {rad_q[SQ_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[ROOT_W-2:0], ge};
    end
  end

  assign root_o = root_q;
  assign done_o = (iter_q == '0);

endmodule

[hdl/ecl_datapath.sv]
// position registers, running sum, point count, end-pair flags and result register
// depends on ecl_pkg, ecl_dist and ecl_isqrt
`timescale 1ns / 1ps

module ecl_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ecl_pkg::in_word_t  in_data_i,
  input  ecl_pkg::dp_cmd_t   cmd_i,
  output ecl_pkg::dp_sts_t   sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ecl_pkg::out_word_t out_data_o
);
  import ecl_pkg::*;

  point_t src_q, tgt_q, first_q, prev_q, cur_q;
  logic [1:0]             op_q;
  logic                   last_q;
  pair_e                  pair_q;
  point_t                 pa, pb;
  logic [SQ_W-1:0]        sq;
  logic                   sq_done;
  logic [ROOT_W-1:0]      root;
  logic                   root_done;
  logic [SQ_W-1:0]        hold_q;
  logic                   flag_a_q, flag_b_q;
  logic [LENGTH_BITS-1:0] sum_q;
  logic [COUNT_BITS-1:0]  count_q;
  logic [ACC_W-1:0]       acc;
  logic [ACC_W-1:0]       root_ext;
  logic [LENGTH_BITS-1:0] sum_sat;
  logic                   out_valid_q;
  out_word_t              out_q;

  always_comb begin
    unique case (pair_q)
      P_CUR_PREV:  begin pa = cur_q; pb = prev_q;  end
      P_TGT_SRC:   begin pa = tgt_q; pb = src_q;   end
      P_SRC_FIRST: begin pa = src_q; pb = first_q; end
      P_SRC_PREV:  begin pa = src_q; pb = prev_q;  end
      P_TGT_PREV:  begin pa = tgt_q; pb = prev_q;  end
      P_TGT_FIRST: begin pa = tgt_q; pb = first_q; end
      default:     begin pa = cur_q; pb = prev_q;  end
    endcase
  end

  ecl_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sq_start),
    .a_i     (pa),
    .b_i     (pb),
    .sq_o    (sq),
    .done_o  (sq_done)
  );

  ecl_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.root_start),
    .rad_i   (sq),
    .root_o  (root),
    .done_o  (root_done)
  );

  // saturating add of a root into the running sum
  assign root_ext = ACC_W'(root);
  assign acc      = ACC_W'(sum_q) + root_ext;
  assign sum_sat  = (|acc[ACC_W-1:LENGTH_BITS]) ? '1 : acc[LENGTH_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q       <= '0;
      tgt_q       <= '0;
      first_q     <= '0;
      prev_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      flag_a_q    <= 1'b0;
      flag_b_q    <= 1'b0;
      pair_q      <= P_CUR_PREV;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.store_src) begin
        src_q <= cur_q;
      end
      if (cmd_i.store_tgt) begin
        tgt_q <= cur_q;
      end
      if (cmd_i.store_first) begin
        first_q <= cur_q;
        prev_q  <= cur_q;
      end
      if (cmd_i.seg_commit) begin
        prev_q <= cur_q;
      end
      if (cmd_i.store_first || cmd_i.seg_commit) begin
        if (count_q != COUNT_MAX) begin
          count_q <= count_q + COUNT_BITS'(1);
        end
      end
      if (cmd_i.seg_commit || cmd_i.add_root) begin
        sum_q <= sum_sat;
      end
      if (cmd_i.load_root) begin
        sum_q <= root_ext[LENGTH_BITS-1:0];
      end
      if (cmd_i.sq_start) begin
        pair_q <= cmd_i.pair;
      end
      if (cmd_i.cmp_a) begin
        flag_a_q <= hold_q < sq;
      end
      if (cmd_i.cmp_b) begin
        flag_b_q <= hold_q < sq;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        sum_q       <= '0;
        count_q     <= '0;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      cur_q[0] <= in_data_i.x;
      cur_q[1] <= in_data_i.y;
      cur_q[2] <= in_data_i.z;
      op_q     <= in_data_i.operation;
      last_q   <= in_data_i.last;
    end
    if (cmd_i.hold_sq) begin
      hold_q <= sq;
    end
    if (cmd_i.emit) begin
      out_q.length      <= sum_q;
      out_q.point_count <= count_q;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.last      = last_q;
  assign sts_o.cnt_zero  = (count_q == '0);
  assign sts_o.sq_done   = sq_done;
  assign sts_o.root_done = root_done;
  assign sts_o.flag_a    = flag_a_q;
  assign sts_o.flag_b    = flag_b_q;
  assign sts_o.out_full  = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hdl/ecl_ctrl.sv]
// sequencer that steps the datapath through segment, end-pair and result work
// depends on ecl_pkg
`timescale 1ns / 1ps

module ecl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ecl_pkg::dp_sts_t sts_i,
  output ecl_pkg::dp_cmd_t cmd_o
);
  import ecl_pkg::*;

  state_e state_q, state_d;
  logic   swap;

  assign swap = sts_i.flag_a && sts_i.flag_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_CHECK;
        unique case (sts_i.op)
          OP_SRC: cmd_o.store_src = 1'b1;
          OP_TGT: cmd_o.store_tgt = 1'b1;
          OP_POINT: begin
            if (sts_i.cnt_zero) begin
              cmd_o.store_first = 1'b1;
            end else begin
              cmd_o.sq_start = 1'b1;
              cmd_o.pair     = P_CUR_PREV;
              state_d        = S_SEG_SQ;
            end
          end
          default: state_d = S_CHECK;
        endcase
      end
      S_SEG_SQ: begin
        if (sts_i.sq_done) begin
          cmd_o.root_start = 1'b1;
          state_d          = S_SEG_RT;
        end
      end
      S_SEG_RT: begin
        if (sts_i.root_done) begin
          cmd_o.seg_commit = 1'b1;
          state_d          = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts_i.last) begin
          state_d = S_IDLE;
        end else if (sts_i.cnt_zero) begin
          cmd_o.sq_start = 1'b1;
          cmd_o.pair     = P_TGT_SRC;
          state_d        = S_NN_SQ;
        end else begin
          cmd_o.sq_start = 1'b1;
          cmd_o.pair     = P_SRC_FIRST;
          state_d        = S_SF;
        end
      end
      S_NN_SQ: begin
        if (sts_i.sq_done) begin
          cmd_o.root_start = 1'b1;
          state_d          = S_NN_RT;
        end
      end
      S_NN_RT: begin
        // last root of the word: node-to-node length or second end distance
        if (sts_i.root_done && !sts_i.out_full) begin
          if (sts_i.cnt_zero) begin
            cmd_o.load_root = 1'b1;
          end else begin
            cmd_o.add_root = 1'b1;
          end
          state_d = S_E2_RT;
        end
      end
      S_SF: begin
        if (sts_i.sq_done) begin
          cmd_o.hold_sq  = 1'b1;
          cmd_o.sq_start = 1'b1;
          cmd_o.pair     = P_SRC_PREV;
          state_d        = S_SL;
        end
      end
      S_SL: begin
        if (sts_i.sq_done) begin
          cmd_o.cmp_a    = 1'b1;
          cmd_o.sq_start = 1'b1;
          cmd_o.pair     = P_TGT_PREV;
          state_d        = S_TL;
        end
      end
      S_TL: begin
        if (sts_i.sq_done) begin
          cmd_o.hold_sq  = 1'b1;
          cmd_o.sq_start = 1'b1;
          cmd_o.pair     = P_TGT_FIRST;
          state_d        = S_TF;
        end
      end
      S_TF: begin
        if (sts_i.sq_done) begin
          cmd_o.cmp_b = 1'b1;
          state_d     = S_E1;
        end
      end
      S_E1: begin
        cmd_o.sq_start = 1'b1;
        cmd_o.pair     = swap ? P_SRC_FIRST : P_SRC_PREV;
        state_d        = S_E1_SQ;
      end
      S_E1_SQ: begin
        if (sts_i.sq_done) begin
          cmd_o.root_start = 1'b1;
          state_d          = S_E1_RT;
        end
      end
      S_E1_RT: begin
        if (sts_i.root_done) begin
          cmd_o.add_root = 1'b1;
          cmd_o.sq_start = 1'b1;
          cmd_o.pair     = swap ? P_TGT_PREV : P_TGT_FIRST;
          state_d        = S_E2_SQ;
        end
      end
      S_E2_SQ: begin
        if (sts_i.sq_done) begin
          cmd_o.root_start = 1'b1;
          state_d          = S_NN_RT;
        end
      end
      S_E2_RT: begin
        // emit step once the last root is in the sum
        if (!sts_i.out_full) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[hdl/ecl_checker.sv]
// port-level checks for the edge contour length block, bound to the top level
// depends on ecl_pkg
`timescale 1ns / 1ps

module ecl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input ecl_pkg::in_word_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ecl_pkg::out_word_t out_data_o
);
  import ecl_pkg::*;

  // stalled result word stays valid and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word dropped or changed while stalled");

  // waiting input word stays valid and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word dropped or changed while waiting");

  // one word at a time: no accept in the decode and check steps after each accept
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken again too soon");

  // a new result only comes out of a busy cycle, never from idle
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without work in progress");

endmodule

bind edge_contour_length ecl_checker u_ecl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
